// ===== hw/rtl/cowd_pkg.sv =====
package cowd_pkg;

    localparam int ROW_W    = 32;
    localparam int LEN_W    = 35;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int MODE_W   = 2;
    localparam int CFG_IDX_W = 1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_LENGTH = 1'd1;

    // offset width modes
    localparam logic [MODE_W-1:0] MODE_NARROW = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WIDE16 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WIDE32 = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_PREFIX   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_ZERO_ROW = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LEN_MISMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_WIDTH    = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DECREASING   = 3'd5;

    typedef struct packed {
        logic [ROW_W-1:0] row_count;
        logic [LEN_W-1:0] buffer_length;
    } cfg_t;

    typedef struct packed {
        logic                emit;
        logic [ROW_W-1:0]    row_size;
        logic                row_valid;
        logic [STATUS_W-1:0] status;
        logic                done_res;
    } res_t;

endpackage

// ===== hw/rtl/cowd_cfg.sv =====
module cowd_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [cowd_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [cowd_pkg::LEN_W-1:0]          wr_data,
    output cowd_pkg::cfg_t                      cfg
);

    logic [cowd_pkg::ROW_W-1:0] row_count_reg;
    logic [cowd_pkg::LEN_W-1:0] buffer_length_reg;

    // take register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg     <= '0;
            buffer_length_reg <= cowd_pkg::LEN_W'(1);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                cowd_pkg::REG_ROW_COUNT:
                    row_count_reg <= wr_data[cowd_pkg::ROW_W-1:0];
                cowd_pkg::REG_BUFFER_LENGTH:
                    buffer_length_reg <= wr_data;
                default:
                    ;
            endcase
        end
    end

    assign cfg.row_count     = row_count_reg;
    assign cfg.buffer_length = buffer_length_reg;

endmodule

// ===== hw/rtl/cowd_core.sv =====
module cowd_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cowd_pkg::cfg_t              cfg,
    input  logic                        fire,
    input  logic [cowd_pkg::BYTE_W-1:0] data_byte,
    output cowd_pkg::res_t              res
);

    localparam int WIDE_W = cowd_pkg::LEN_W + 1;

    logic [cowd_pkg::LEN_W-1:0]  pos_reg, pos_next;
    logic [cowd_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [cowd_pkg::ROW_W-1:0]  asm_reg, asm_next;
    logic [cowd_pkg::ROW_W-1:0]  prev_reg, prev_next;
    logic                        failed_reg, failed_next;

    logic [cowd_pkg::LEN_W-1:0]    len;
    logic [WIDE_W-1:0]             pos_inc;
    logic [WIDE_W-1:0]             len_w;
    logic [WIDE_W-1:0]             n_w;
    logic                          last;
    logic [cowd_pkg::STATUS_W-1:0] err;
    logic                          row_done;
    logic                          have_row;
    logic [cowd_pkg::ROW_W-1:0]    cum;
    logic [cowd_pkg::ROW_W-1:0]    size;
    logic [1:0]                    lanes_mask;
    logic [1:0]                    lane;
    logic [cowd_pkg::BYTE_W-1:0]   want;

    // decode one byte against the current buffer state
    always_comb
    begin
        len      = (cfg.buffer_length == '0) ? cowd_pkg::LEN_W'(1) : cfg.buffer_length;
        pos_inc  = {1'b0, pos_reg} + WIDE_W'(1);
        len_w    = {1'b0, len};
        n_w      = WIDE_W'(cfg.row_count);
        last     = (pos_inc >= len_w);
        err      = cowd_pkg::ST_OK;
        row_done = 1'b0;
        have_row = 1'b0;
        cum      = '0;
        size     = '0;
        mode_next = mode_reg;
        asm_next  = asm_reg;
        prev_next = prev_reg;
        lanes_mask = (mode_reg == cowd_pkg::MODE_WIDE16) ? 2'd1 : 2'd3;
        lane       = (pos_reg[1:0] - 2'd2) & lanes_mask;
        want       = (mode_reg == cowd_pkg::MODE_WIDE16) ? 8'd0 : 8'd1;

        if (failed_reg)
        begin
            // drop the rest of a failed buffer
        end
        else if (pos_reg == '0)
        begin
            // pick the format from prefix byte and registers
            if (data_byte != '0)
                err = cowd_pkg::ST_BAD_PREFIX;
            else if (cfg.row_count == '0)
            begin
                if (len != cowd_pkg::LEN_W'(1))
                    err = cowd_pkg::ST_BAD_ZERO_ROW;
            end
            else if (len_w == n_w + WIDE_W'(1))
                mode_next = cowd_pkg::MODE_NARROW;
            else if (len_w == (n_w << 1) + WIDE_W'(2))
                mode_next = cowd_pkg::MODE_WIDE16;
            else if (len_w == (n_w << 2) + WIDE_W'(2))
                mode_next = cowd_pkg::MODE_WIDE32;
            else
                err = cowd_pkg::ST_LEN_MISMATCH;
        end
        else if (mode_reg == cowd_pkg::MODE_NARROW)
        begin
            cum      = cowd_pkg::ROW_W'(data_byte);
            row_done = 1'b1;
        end
        else if (pos_reg == cowd_pkg::LEN_W'(1))
        begin
            // check the width byte
            if (data_byte != want)
                err = cowd_pkg::ST_BAD_WIDTH;
        end
        else
        begin
            // assemble a little-endian offset
            if (lane == 2'd0)
                asm_next = cowd_pkg::ROW_W'(data_byte);
            else
                asm_next = asm_reg | (cowd_pkg::ROW_W'(data_byte) << {lane, 3'b000});
            if (lane == lanes_mask)
            begin
                cum      = asm_next;
                row_done = 1'b1;
            end
        end

        // turn the offset into a row size
        if (row_done)
        begin
            if (cum < prev_reg)
                err = cowd_pkg::ST_DECREASING;
            else
            begin
                have_row  = 1'b1;
                size      = cum - prev_reg;
                prev_next = cum;
            end
        end

        res.emit      = (err != cowd_pkg::ST_OK) || have_row || (last && !failed_reg);
        res.row_size  = have_row ? size : '0;
        res.row_valid = have_row;
        res.status    = err;
        res.done_res  = (err != cowd_pkg::ST_OK) || last;

        // advance or clear at the buffer end
        if (last)
        begin
            pos_next    = '0;
            mode_next   = cowd_pkg::MODE_NARROW;
            asm_next    = '0;
            prev_next   = '0;
            failed_next = 1'b0;
        end
        else
        begin
            pos_next    = pos_inc[cowd_pkg::LEN_W-1:0];
            failed_next = failed_reg || (err != cowd_pkg::ST_OK);
        end
    end

    // hold buffer state between requests
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            mode_reg   <= cowd_pkg::MODE_NARROW;
            asm_reg    <= '0;
            prev_reg   <= '0;
            failed_reg <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg    <= pos_next;
            mode_reg   <= mode_next;
            asm_reg    <= asm_next;
            prev_reg   <= prev_next;
            failed_reg <= failed_next;
        end
    end

endmodule

// ===== hw/rtl/cumulative_offset_width_decoder.sv =====
// Path: an accepted byte is held in the input register; the result it causes, if any, goes to the result register.
// Throughput: one byte per cycle while results are taken; in_stall follows out_stall
// combinationally when both the input register and the result register hold a request.
// Reset: asynchronous, active low; clears buffer state and both pipeline valid
// flags, sets row_count to 0 and buffer_length to 1.
module cumulative_offset_width_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [cowd_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [cowd_pkg::LEN_W-1:0]          wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cowd_pkg::BYTE_W-1:0]         data_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [cowd_pkg::ROW_W-1:0]          row_size,
    output logic                                row_valid,
    output logic [cowd_pkg::STATUS_W-1:0]       status,
    output logic                                done_res
);

    cowd_pkg::cfg_t cfg;
    cowd_pkg::res_t res;

    logic                        in_valid_reg;
    logic [cowd_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        out_valid_reg;
    cowd_pkg::res_t              out_reg;
    logic                        advance;
    logic                        fire;

    cowd_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    cowd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .fire      (fire),
        .data_byte (in_byte_reg),
        .res       (res)
    );

    // move on unless a result waits on a stalled consumer
    assign advance  = !(out_valid_reg && out_stall);
    assign fire     = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;

    // capture the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= data_byte;
    end

    // load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= fire && res.emit;
    end

    always_ff @(posedge clk)
    begin
        if (fire && res.emit)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign row_size  = out_reg.row_size;
    assign row_valid = out_reg.row_valid;
    assign status    = out_reg.status;
    assign done_res  = out_reg.done_res;

endmodule

// ===== hw/rtl/cowd_checker.sv =====
module cowd_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic [cowd_pkg::ROW_W-1:0]          row_size,
    input  logic                                row_valid,
    input  logic [cowd_pkg::STATUS_W-1:0]       status,
    input  logic                                done_res
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(row_size) && $stable(status)
            && $stable(row_valid) && $stable(done_res))
        else $error("stalled result changed");

    // an error ends the buffer and carries no row
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != cowd_pkg::ST_OK) |-> done_res && !row_valid && (row_size == '0))
        else $error("error result malformed");

    // a result without a row carries a zero size and ends the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !row_valid |-> (row_size == '0) && done_res)
        else $error("rowless result malformed");

    // status stays within the defined codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status <= cowd_pkg::ST_DECREASING))
        else $error("undefined status code");

endmodule

bind cumulative_offset_width_decoder cowd_checker u_cowd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .row_size  (row_size),
    .row_valid (row_valid),
    .status    (status),
    .done_res  (done_res)
);

// ===== test/cumulative_offset_width_decoder_tb.sv =====
module cumulative_offset_width_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cowd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 200;

    // buffer defects injected by the random buffer builder
    localparam int FLAW_NONE      = 0;
    localparam int FLAW_PREFIX    = 1;
    localparam int FLAW_WIDTH     = 2;
    localparam int FLAW_DECREASE  = 3;
    localparam int FLAW_LENGTH    = 4;
    localparam int FLAW_ZERO_ROWS = 5;

    typedef struct packed {
        logic [ROW_W-1:0]    row_size;
        logic                row_valid;
        logic [STATUS_W-1:0] status;
        logic                done_res;
    } row_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [LEN_W-1:0]     wr_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    data_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [ROW_W-1:0]     row_size;
    logic                 row_valid;
    logic [STATUS_W-1:0]  status;
    logic                 done_res;

    // decoder shadow: configuration and per-buffer state
    logic [ROW_W-1:0]  rows_cfg;
    logic [LEN_W-1:0]  len_cfg;
    logic [LEN_W-1:0]  byte_pos;
    logic [MODE_W-1:0] width_mode;
    logic [ROW_W-1:0]  word_acc;
    logic [ROW_W-1:0]  prev_off;
    logic              buf_failed;

    row_result_t rows_due[$];
    row_result_t got_due;

    // current control buffer under construction
    logic [BYTE_W-1:0] buf_bytes[$];
    logic [ROW_W-1:0]  buf_rows;
    logic [LEN_W-1:0]  buf_len;
    int                shape_rows;
    logic [MODE_W-1:0] shape_mode;
    int                shape_flaw;

    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_left;
    int          mismatches;
    int          bytes_sent;
    int          bytes_decoded;
    int          buffers_sent;
    int          sizes_checked;
    int          errors_checked;
    int          finals_checked;
    int unsigned cycle_count;

    cumulative_offset_width_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .row_size  (row_size),
        .row_valid (row_valid),
        .status    (status),
        .done_res  (done_res)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decode one accepted byte and queue the result it causes, if any.
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        longint unsigned eff_len;
        longint unsigned n;
        logic            last;
        logic            have_row;
        logic            row_done;
        logic [2:0]      err;
        logic [31:0]     cum;
        logic [31:0]     size;
        logic [1:0]      lane_mask;
        logic [1:0]      lane;
        row_result_t     r;

        eff_len = 64'(len_cfg);
        if (eff_len == 0)
        begin
            eff_len = 1;
        end
        n = 64'(rows_cfg);
        last = (byte_pos + 64'd1 >= eff_len);
        err = ST_OK;
        have_row = 1'b0;
        row_done = 1'b0;
        cum = '0;
        size = '0;

        if (!buf_failed)
        begin
            bytes_decoded++;
        end

        if (buf_failed)
        begin
            // rest of a failed buffer is dropped
        end
        else if (byte_pos == 0)
        begin
            // pick the format from the registers on the first byte
            if (b != 0)
                err = ST_BAD_PREFIX;
            else if (n == 0)
            begin
                if (eff_len != 1)
                    err = ST_BAD_ZERO_ROW;
            end
            else if (eff_len == 1 + n)
                width_mode = MODE_NARROW;
            else if (eff_len == 2 + 2 * n)
                width_mode = MODE_WIDE16;
            else if (eff_len == 2 + 4 * n)
                width_mode = MODE_WIDE32;
            else
                err = ST_LEN_MISMATCH;
        end
        else if (width_mode == MODE_NARROW)
        begin
            cum = {24'd0, b};
            row_done = 1'b1;
        end
        else if (byte_pos == 1)
        begin
            if (b != ((width_mode == MODE_WIDE16) ? 8'd0 : 8'd1))
                err = ST_BAD_WIDTH;
        end
        else
        begin
            // assemble a little-endian offset lane by lane
            lane_mask = (width_mode == MODE_WIDE16) ? 2'd1 : 2'd3;
            lane = (byte_pos[1:0] - 2'd2) & lane_mask;
            if (lane == 0)
                word_acc = {24'd0, b};
            else
                word_acc = word_acc | ({24'd0, b} << (8 * lane));
            if (lane == lane_mask)
            begin
                cum = word_acc;
                row_done = 1'b1;
            end
        end

        if (row_done)
        begin
            if (cum < prev_off)
                err = ST_DECREASING;
            else
            begin
                have_row = 1'b1;
                size = cum - prev_off;
                prev_off = cum;
            end
        end

        if (err != ST_OK || have_row || (last && !buf_failed))
        begin
            r.row_size = have_row ? size : '0;
            r.row_valid = have_row;
            r.status = err;
            r.done_res = (err != ST_OK) || last;
            rows_due.insert(rows_due.size(), r);
        end

        // advance or clear the buffer state
        if (last)
        begin
            byte_pos = '0;
            width_mode = MODE_NARROW;
            word_acc = '0;
            prev_off = '0;
            buf_failed = 1'b0;
        end
        else
        begin
            byte_pos = byte_pos + 1'b1;
            if (err != ST_OK)
                buf_failed = 1'b1;
        end
    endtask

    // Offer one byte, hold it until accepted, then idle at random.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        in_valid <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b);
        bytes_sent++;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_buffer();
        int i;

        for (i = 0; i < buf_bytes.size(); i++)
            send_byte(buf_bytes[i]);
        buffers_sent++;
    endtask

    // Drop valid, wait for every queued result, then let the pipeline empty.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (rows_due.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= value;
        @(negedge clk);
        wr_en <= 1'b0;
        @(negedge clk);
        if (idx == REG_ROW_COUNT)
            rows_cfg = value[ROW_W-1:0];
        else
            len_cfg = value;
    endtask

    task automatic set_format(input logic [ROW_W-1:0] rows, input logic [LEN_W-1:0] len);
        write_reg(REG_ROW_COUNT, {3'd0, rows});
        write_reg(REG_BUFFER_LENGTH, len);
    endtask

    // Choose row count, format and defect for the next random buffer.
    task automatic roll_shape();
        int pick;

        pick = $urandom_range(0, 99);
        if (pick < 75)
            shape_flaw = FLAW_NONE;
        else
            shape_flaw = $urandom_range(FLAW_PREFIX, FLAW_ZERO_ROWS);
        pick = $urandom_range(0, 2);
        if (pick == 0)
            shape_mode = MODE_NARROW;
        else if (pick == 1)
            shape_mode = MODE_WIDE16;
        else
            shape_mode = MODE_WIDE32;
        shape_rows = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        if ($urandom_range(0, 11) == 0 && (shape_flaw == FLAW_NONE || shape_flaw == FLAW_PREFIX))
            shape_rows = 0;
        if (shape_flaw == FLAW_DECREASE && shape_rows < 2)
            shape_rows = 2;
        if (shape_flaw == FLAW_WIDTH && shape_mode == MODE_NARROW)
            shape_mode = MODE_WIDE32;
    endtask

    // Fill buf_bytes with sorted offsets in the chosen format, then apply the defect.
    task automatic build_buffer();
        logic [31:0] offs[$];
        logic [31:0] v;
        logic [31:0] mask;
        int          lanes;
        int          i;
        int          k;
        int          j;

        buf_bytes.delete();
        buf_rows = ROW_W'(shape_rows);
        if (shape_mode == MODE_NARROW)
        begin
            mask = 32'h0000_00FF;
            lanes = 1;
            buf_len = LEN_W'(1 + shape_rows);
        end
        else if (shape_mode == MODE_WIDE16)
        begin
            mask = 32'h0000_FFFF;
            lanes = 2;
            buf_len = LEN_W'(2 + 2 * shape_rows);
        end
        else
        begin
            mask = 32'hFFFF_FFFF;
            lanes = 4;
            buf_len = LEN_W'(2 + 4 * shape_rows);
        end

        buf_bytes.insert(buf_bytes.size(), 8'h00);
        if (shape_rows == 0)
        begin
            buf_len = LEN_W'(1);
        end
        else
        begin
            // mix of tiny and full-range offsets so sizes of zero also show up
            for (i = 0; i < shape_rows; i++)
            begin
                v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : $urandom;
                offs.insert(offs.size(), v & mask);
            end
            offs.sort();
            if (shape_flaw == FLAW_DECREASE)
            begin
                j = $urandom_range(1, shape_rows - 1);
                if (offs[j-1] == 0)
                    offs[j-1] = 32'd1;
                offs[j] = offs[j-1] - 1'b1;
            end
            if (shape_mode != MODE_NARROW)
                buf_bytes.insert(buf_bytes.size(),
                                 (shape_mode == MODE_WIDE16) ? 8'h00 : 8'h01);
            for (i = 0; i < shape_rows; i++)
                for (k = 0; k < lanes; k++)
                    buf_bytes.insert(buf_bytes.size(), offs[i][8*k +: 8]);
        end

        if (shape_flaw == FLAW_PREFIX)
            buf_bytes[0] = 8'($urandom_range(1, 255));
        else if (shape_flaw == FLAW_WIDTH)
            buf_bytes[1] = buf_bytes[1] ^ 8'($urandom_range(1, 255));
        else if (shape_flaw == FLAW_LENGTH)
        begin
            buf_len = buf_len + 1'b1;
            buf_bytes.insert(buf_bytes.size(), 8'($urandom));
        end
        else if (shape_flaw == FLAW_ZERO_ROWS)
            buf_rows = '0;
    endtask

    // Zero-row buffers, nonzero prefix and a zero buffer length.
    task automatic test_zero_rows_and_prefix();
        buf_bytes = {8'h00};
        send_buffer();
        buf_bytes = {8'hFF};
        send_buffer();
        drain_results();
        set_format(32'd0, 35'd3);
        buf_bytes = {8'h00, 8'hAA, 8'h55};
        send_buffer();
        drain_results();
        set_format(32'd0, 35'd0);
        buf_bytes = {8'h00};
        send_buffer();
    endtask

    // Decreasing offset, widest u16 row, length mismatch at the register extremes.
    task automatic test_format_errors();
        drain_results();
        set_format(32'd2, 35'd3);
        buf_bytes = {8'h00, 8'h09, 8'h04};
        send_buffer();
        drain_results();
        set_format(32'd1, 35'd4);
        buf_bytes = {8'h00, 8'h00, 8'hFF, 8'hFF};
        send_buffer();
        drain_results();
        set_format(32'hFFFF_FFFF, 35'h7_FFFF_FFFF);
        buf_bytes = {8'h00};
        send_buffer();
        // end the failed buffer by shrinking its length
        drain_results();
        write_reg(REG_BUFFER_LENGTH, 35'd1);
        buf_bytes = {8'h33};
        send_buffer();
    endtask

    // Largest u32 row, then cut the buffer short on a byte that completes no row.
    task automatic test_mid_buffer_resize();
        drain_results();
        set_format(32'hFFFF_FFFF, 35'h3_FFFF_FFFE);
        buf_bytes = {8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_buffer();
        drain_results();
        write_reg(REG_BUFFER_LENGTH, 35'd0);
        buf_bytes = {8'h5A};
        send_buffer();
    endtask

    // Stream random buffers, reusing the format often so buffers run back to back.
    task automatic test_random_buffers(input int idle_pct, input int stall_pct,
                                       input int item_goal);
        int start;

        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        roll_shape();
        while (bytes_sent - start < item_goal)
        begin
            if ($urandom_range(0, 1) == 0)
                roll_shape();
            build_buffer();
            if (buf_rows != rows_cfg || buf_len != len_cfg)
            begin
                drain_results();
                set_format(buf_rows, buf_len);
            end
            send_buffer();
        end
    endtask

    // Hold the receiver off while a long buffer is offered, then wait for all results.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        shape_rows = 80;
        shape_mode = MODE_NARROW;
        shape_flaw = FLAW_NONE;
        build_buffer();
        drain_results();
        set_format(buf_rows, buf_len);
        hold_left = 200;
        send_buffer();
        drain_results();
    endtask

    // Receiver side: long hold-off when requested, random stalls otherwise.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare each accepted result with the oldest queued one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (rows_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result size=%h valid=%b status=%0d done=%b",
                             $time, row_size, row_valid, status, done_res);
            end
            else
            begin
                got_due = rows_due.pop_front();
                if (got_due.row_size !== row_size || got_due.row_valid !== row_valid ||
                    got_due.status !== status || got_due.done_res !== done_res)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"%0t: mismatch expected size=%h valid=%b status=%0d done=%b",
                                  " got size=%h valid=%b status=%0d done=%b"}, $time,
                                 got_due.row_size, got_due.row_valid, got_due.status,
                                 got_due.done_res, row_size, row_valid, status, done_res);
                end
                if (got_due.row_valid)
                    sizes_checked++;
                if (got_due.status != ST_OK)
                    errors_checked++;
                if (got_due.done_res)
                    finals_checked++;
            end
        end
    end

    // Stop a hung run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run stopped after %0d cycles, %0d results outstanding",
                 $time, cycle_count, rows_due.size());
        $display("cumulative_offset_width_decoder verification failed");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = '0;
        wr_data = '0;
        in_valid = 1'b0;
        data_byte = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        mismatches = 0;
        bytes_sent = 0;
        bytes_decoded = 0;
        buffers_sent = 0;
        sizes_checked = 0;
        errors_checked = 0;
        finals_checked = 0;
        rows_cfg = '0;
        len_cfg = 35'd1;
        byte_pos = '0;
        width_mode = MODE_NARROW;
        word_acc = '0;
        prev_off = '0;
        buf_failed = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_zero_rows_and_prefix();
        test_format_errors();
        test_mid_buffer_resize();
        test_random_buffers(0, 0, 300);
        test_random_buffers(56, 0, 300);
        test_backpressure();
        test_random_buffers(0, 56, 300);
        test_random_buffers(38, 38, 300);

        drain_results();
        $display("Sent %0d bytes in %0d buffers, %0d of them outside failed buffers.",
                 bytes_sent, buffers_sent, bytes_decoded);
        $display("Checked %0d row sizes and %0d final results, %0d of them errors.",
                 sizes_checked, finals_checked, errors_checked);
        if (mismatches == 0)
            $display("cumulative_offset_width_decoder verification clean");
        else
            $display("cumulative_offset_width_decoder verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cowd_pkg.sv
hw/rtl/cowd_cfg.sv
hw/rtl/cowd_core.sv
hw/rtl/cumulative_offset_width_decoder.sv
hw/rtl/cowd_checker.sv
test/cumulative_offset_width_decoder_tb.sv
